>>> hw/rtl/scaled_reload_timer_bank_assert.svh
// Assertion macros used by the timer bank checker.
`ifndef SCALED_RELOAD_TIMER_BANK_ASSERT_SVH
`define SCALED_RELOAD_TIMER_BANK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRTB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer bank check failed");

// Consequent must hold in the cycle after the antecedent.
`define SRTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer bank check failed");

`endif

>>> hw/rtl/srtb_pkg.sv
// Types and constants shared by the timer bank and its checker.
package srtb_pkg;

   localparam int NUM_TIMERS_DEF = 16;

   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_RELOAD = 2'd1;
   localparam logic [1:0] ACT_ADD    = 2'd2;
   localparam logic [1:0] ACT_REMOVE = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] dt;
      logic [30:0] period;
      logic [15:0] speed_scale;
      logic [3:0]  slot_index;
   } srtb_req_type;

   typedef struct packed {
      logic [3:0]  slot_taken;
      logic        ok;
      logic [15:0] done_mask;
   } srtb_rsp_type;

endpackage

>>> hw/rtl/scaled_reload_timer_bank.sv
// Scaled auto-reload timer bank: NUM_TIMERS countdown slots driven by one shared multiplier.
//
// Each request is one action: tick, reload expired, add timer or remove timer. Tick and
// reload walk the slots one per cycle through a single dt*scale multiplier followed by a
// write-back stage that subtracts and saturates on tick and adds the period on reload.
// Add scans for the lowest free slot one slot per cycle. A new request is accepted once
// the sequencer is idle, even while the previous response still waits in the output
// register. Counts are Q16.16, periods are Q15.16, dt is Q0.16, scale is Q8.8; a ticked
// count saturates at -2^31.
module scaled_reload_timer_bank #(
   parameter int NUM_TIMERS = srtb_pkg::NUM_TIMERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  srtb_pkg::srtb_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output srtb_pkg::srtb_rsp_type rsp_data
);
   import srtb_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
   localparam logic [4:0] NUM_SLOTS = 5'(NUM_TIMERS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            act_ff, act_in;
   logic [15:0]           dt_ff, dt_in;
   logic [30:0]           period_ff, period_in;
   logic [15:0]           scale_ff, scale_in;
   logic [IDX_W-1:0]      cursor_ff, cursor_in;
   logic                  ok_ff, ok_in;
   logic [IDX_W-1:0]      taken_ff, taken_in;
   logic [NUM_TIMERS-1:0] in_use_ff, in_use_in;
   logic [NUM_TIMERS-1:0] done_ff, done_in;
   logic                  s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0]      s1_idx_ff, s1_idx_in;
   logic [31:0]           prod_ff, prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   srtb_rsp_type          rsp_data_ff, rsp_data_in;

   logic [31:0] cnt_ff [NUM_TIMERS];
   logic [30:0] per_mem_ff [NUM_TIMERS];
   logic [15:0] scl_mem_ff [NUM_TIMERS];

   logic             cnt_we;
   logic [31:0]      cnt_wd;
   logic             add_we;
   logic [31:0]      cnt_old;
   logic [32:0]      diff;
   logic [31:0]      tick_val;
   logic [31:0]      reload_val;
   logic             old_le0;

   // Write-back: the slot issued last cycle is updated by its registered product or period.
   always_comb begin
      cnt_old    = cnt_ff[s1_idx_ff];
      diff       = {cnt_old[31], cnt_old} - {9'd0, prod_ff[31:8]};
      tick_val   = (diff[32] != diff[31]) ? 32'h8000_0000 : diff[31:0];
      reload_val = cnt_old + {1'b0, per_mem_ff[s1_idx_ff]};
      old_le0    = cnt_old[31] || (cnt_old == 32'd0);
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      dt_in        = dt_ff;
      period_in    = period_ff;
      scale_in     = scale_ff;
      cursor_in    = cursor_ff;
      ok_in        = ok_ff;
      taken_in     = taken_ff;
      in_use_in    = in_use_ff;
      done_in      = done_ff;
      s1_vld_in    = 1'b0;
      s1_idx_in    = s1_idx_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cnt_we       = 1'b0;
      cnt_wd       = tick_val;
      add_we       = 1'b0;

      if (s1_vld_ff) begin
         if (act_ff == ACT_TICK) begin
            cnt_we = 1'b1;
            cnt_wd = tick_val;
            if (tick_val[31] || (tick_val == 32'd0)) begin
               done_in[s1_idx_ff] = 1'b1;
            end
         end else if (old_le0) begin
            cnt_we = 1'b1;
            cnt_wd = reload_val;
            done_in[s1_idx_ff] = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in    = req_data.action;
               dt_in     = req_data.dt;
               period_in = req_data.period;
               scale_in  = req_data.speed_scale;
               cursor_in = '0;
               ok_in     = 1'b1;
               taken_in  = '0;
               if (req_data.action == ACT_REMOVE) begin
                  if ({1'b0, req_data.slot_index} < NUM_SLOTS) begin
                     in_use_in[req_data.slot_index[IDX_W-1:0]] = 1'b0;
                     done_in[req_data.slot_index[IDX_W-1:0]]   = 1'b0;
                  end else begin
                     ok_in = 1'b0;
                  end
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (act_ff == ACT_ADD) begin
               if (!in_use_ff[cursor_ff]) begin
                  add_we             = 1'b1;
                  in_use_in[cursor_ff] = 1'b1;
                  done_in[cursor_ff]   = 1'b0;
                  taken_in           = cursor_ff;
                  state_in           = ST_FIN;
               end else if (cursor_ff == LAST_IDX) begin
                  ok_in    = 1'b0;
                  state_in = ST_FIN;
               end else begin
                  cursor_in = cursor_ff + 1'b1;
               end
            end else begin
               s1_vld_in = in_use_ff[cursor_ff];
               s1_idx_in = cursor_ff;
               prod_in   = dt_ff * scl_mem_ff[cursor_ff];
               if (cursor_ff == LAST_IDX) begin
                  state_in = ST_FIN;
               end else begin
                  cursor_in = cursor_ff + 1'b1;
               end
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.slot_taken = 4'(taken_ff);
               rsp_data_in.ok         = ok_ff;
               rsp_data_in.done_mask  = 16'(done_in);
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_use_ff    <= '0;
         done_ff      <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         done_ff      <= done_in;
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      dt_ff       <= dt_in;
      period_ff   <= period_in;
      scale_ff    <= scale_in;
      cursor_ff   <= cursor_in;
      ok_ff       <= ok_in;
      taken_ff    <= taken_in;
      s1_idx_ff   <= s1_idx_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Slot storage. Add and the write-back stage never write in the same cycle.
   always_ff @(posedge clock) begin
      if (add_we) begin
         cnt_ff[cursor_ff]     <= {1'b0, period_ff};
         per_mem_ff[cursor_ff] <= period_ff;
         scl_mem_ff[cursor_ff] <= scale_ff;
      end else if (cnt_we) begin
         cnt_ff[s1_idx_ff] <= cnt_wd;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/srtb_checker.sv
// Port-level checker for the timer bank, bound to the top level.
`include "scaled_reload_timer_bank_assert.svh"

module srtb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input srtb_pkg::srtb_rsp_type rsp_data
);
   import srtb_pkg::*;

   logic req_xfer;
   logic rsp_stall;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // A stalled response must hold its value.
   `SRTB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   // A failed action never reports a claimed slot.
   `SRTB_ASSERT_SAME(a_fail_no_slot, clock, reset, rsp_valid && !rsp_data.ok,
                     rsp_data.slot_taken == 4'd0)
   // Every request keeps the block busy for at least the following cycle.
   `SRTB_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, !req_ready)
   // Reset leaves no response pending.
   `SRTB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind scaled_reload_timer_bank srtb_checker u_srtb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/scaled_reload_timer_bank_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the scaled reload timer bank with a shadow model of the slots.
module scaled_reload_timer_bank_tb;
   import srtb_pkg::*;

   localparam int SLOTS = NUM_TIMERS_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
   localparam int ITEMS_PER_PHASE = 430;
   localparam int SAT_TICKS = 150;
   localparam longint COUNT_FLOOR = -longint'(32'h8000_0000);

   typedef struct {
      srtb_req_type op;
      int           reps;
      bit           typed;
      srtb_rsp_type rsp;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   srtb_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   srtb_rsp_type rsp_data;

   // Shadow copy of the slot state.
   logic               slot_used   [SLOTS];
   logic signed [31:0] slot_count  [SLOTS];
   logic        [30:0] slot_period [SLOTS];
   logic        [15:0] slot_scale  [SLOTS];
   logic               slot_done   [SLOTS];

   srtb_rsp_type pending_rsp_q[$];
   srtb_rsp_type oldest_rsp;
   int           mismatches = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;

   scaled_reload_timer_bank DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one action to the shadow state and returns the result it yields.
   function automatic srtb_rsp_type timer_bank_step(input srtb_req_type op);
      srtb_rsp_type r;
      longint       next_count;
      logic [31:0]  drain;
      bit           claimed;
      r       = '0;
      r.ok    = 1'b1;
      claimed = 1'b0;
      case (op.action)
         ACT_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i]) begin
                  drain = ({16'd0, op.dt} * {16'd0, slot_scale[i]}) >> 8;
                  next_count = longint'(slot_count[i]) - longint'(drain);
                  if (next_count < COUNT_FLOOR) next_count = COUNT_FLOOR;
                  slot_count[i] = next_count[31:0];
                  if (next_count <= 0) slot_done[i] = 1'b1;
               end
            end
         end
         ACT_RELOAD: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && slot_count[i] <= 0) begin
                  slot_count[i] = slot_count[i] + $signed({1'b0, slot_period[i]});
                  slot_done[i]  = 1'b0;
               end
            end
         end
         ACT_ADD: begin
            r.ok = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (!claimed && !slot_used[i]) begin
                  claimed        = 1'b1;
                  slot_used[i]   = 1'b1;
                  slot_count[i]  = {1'b0, op.period};
                  slot_period[i] = op.period;
                  slot_scale[i]  = op.speed_scale;
                  slot_done[i]   = 1'b0;
                  r.slot_taken   = 4'(i);
                  r.ok           = 1'b1;
               end
            end
         end
         default: begin
            if (op.slot_index < SLOTS) begin
               slot_used[op.slot_index] = 1'b0;
               slot_done[op.slot_index] = 1'b0;
            end else begin
               r.ok = 1'b0;
            end
         end
      endcase
      for (int i = 0; i < SLOTS; i++) r.done_mask[i] = slot_done[i];
      return r;
   endfunction

   function automatic stim_row_type make_row(input logic [1:0] act, input logic [15:0] dt,
                                          input logic [30:0] period, input logic [15:0] scale,
                                          input logic [3:0] idx, input int reps, input bit typed,
                                          input logic [3:0] slot, input logic ok,
                                          input logic [15:0] mask);
      stim_row_type row;
      row.op.action         = act;
      row.op.dt             = dt;
      row.op.period         = period;
      row.op.speed_scale    = scale;
      row.op.slot_index     = idx;
      row.reps              = reps;
      row.typed             = typed;
      row.rsp.slot_taken    = slot;
      row.rsp.ok            = ok;
      row.rsp.done_mask     = mask;
      return row;
   endfunction

   // Called just after a falling edge; returns just after the falling edge that
   // follows the transfer.
   task automatic send_op(input srtb_req_type op, input bit typed,
                          input srtb_rsp_type typed_rsp);
      srtb_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= op;
      do @(posedge clock); while (!req_ready);
      predicted = timer_bank_step(op);
      pending_rsp_q.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            $error("rsp transfer with no expected result pending");
            mismatches++;
         end else begin
            oldest_rsp = pending_rsp_q.pop_front();
            if (rsp_data.slot_taken !== oldest_rsp.slot_taken) begin
               $error("slot_taken: expected %0d, got %0d",
                      oldest_rsp.slot_taken, rsp_data.slot_taken);
               mismatches++;
            end
            if (rsp_data.ok !== oldest_rsp.ok) begin
               $error("ok: expected %0d, got %0d", oldest_rsp.ok, rsp_data.ok);
               mismatches++;
            end
            if (rsp_data.done_mask !== oldest_rsp.done_mask) begin
               $error("done_mask: expected %04h, got %04h",
                      oldest_rsp.done_mask, rsp_data.done_mask);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      stim_row_type rows [12];
      srtb_req_type op;
      srtb_rsp_type no_rsp;
      logic [95:0]  noise;
      int           sent;
      int           pick;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      no_rsp    = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_used[i]   = 1'b0;
         slot_count[i]  = '0;
         slot_period[i] = '0;
         slot_scale[i]  = '0;
         slot_done[i]   = 1'b0;
      end

      rows = '{
         // Empty bank: tick and reload touch nothing.
         make_row(ACT_TICK,   16'hFFFF, 31'h0,        16'h0,    4'h0, 1,  1, 4'd0, 1'b1, 16'h0),
         make_row(ACT_RELOAD, 16'h0,    31'h0,        16'h0,    4'h0, 1,  1, 4'd0, 1'b1, 16'h0),
         // A zero period slot is done on the first tick, even with dt zero.
         make_row(ACT_ADD,    16'h0,    31'h0,        16'h0,    4'h0, 1,  1, 4'd0, 1'b1, 16'h0),
         make_row(ACT_TICK,   16'h0,    31'h0,        16'h0,    4'h0, 1,  1, 4'd0, 1'b1, 16'h1),
         make_row(ACT_ADD,    16'h0,    31'h7FFFFFFF, 16'hFFFF, 4'h0, 1,  1, 4'd1, 1'b1, 16'h1),
         make_row(ACT_TICK,   16'hFFFF, 31'h0,        16'h0,    4'h0, 1,  0, 4'd0, 1'b0, 16'h0),
         make_row(ACT_RELOAD, 16'h0,    31'h0,        16'h0,    4'h0, 1,  0, 4'd0, 1'b0, 16'h0),
         make_row(ACT_ADD,    16'h0,    31'h00010000, 16'h0100, 4'h0, 14, 0, 4'd0, 1'b0, 16'h0),
         // Bank full: the add is refused.
         make_row(ACT_ADD,    16'h0,    31'h2AAAAAAA, 16'hAAAA, 4'h0, 1,  1, 4'd0, 1'b0, 16'h0),
         make_row(ACT_TICK,   16'h8000, 31'h0,        16'h0,    4'h0, 2,  0, 4'd0, 1'b0, 16'h0),
         make_row(ACT_REMOVE, 16'h0,    31'h0,        16'h0,    4'hF, 1,  0, 4'd0, 1'b0, 16'h0),
         make_row(ACT_ADD,    16'h5555, 31'h55555555, 16'h5555, 4'h5, 1,  0, 4'd0, 1'b0, 16'h0)
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[r]) begin
         repeat (rows[r].reps) send_op(rows[r].op, rows[r].typed, rows[r].rsp);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 63; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 63; end
            default: begin send_idle_pct = 20; rsp_stall_pct = 20; end
         endcase
         sent = 0;

         // Free a slot, load the lowest free slot with the fastest scale and tick it down
         // until the count pins at its negative limit, then reload it.
         if (phase == 0 || phase == 3) begin
            op            = '0;
            op.action     = ACT_REMOVE;
            op.slot_index = 4'($urandom_range(SLOTS - 1));
            send_op(op, 1'b0, no_rsp);
            op.action      = ACT_ADD;
            op.period      = 31'($urandom_range(32'h0010_0000));
            op.speed_scale = 16'hFFFF;
            send_op(op, 1'b0, no_rsp);
            op.action = ACT_TICK;
            repeat (SAT_TICKS) begin
               op.dt = 16'($urandom_range(16'hFFFF, 16'hF000));
               send_op(op, 1'b0, no_rsp);
            end
            op.action = ACT_RELOAD;
            send_op(op, 1'b0, no_rsp);
            sent = SAT_TICKS + 3;
         end

         while (sent < ITEMS_PER_PHASE) begin
            noise = {$urandom, $urandom, $urandom};
            op    = noise[68:0];
            pick  = $urandom_range(99);
            if (pick < 40) begin
               op.action = ACT_TICK;
            end else if (pick < 55) begin
               op.action = ACT_RELOAD;
            end else if (pick < 75) begin
               op.action = ACT_ADD;
               // Short periods keep slots expiring and reloading often.
               if ($urandom_range(1) == 0) op.period = 31'($urandom_range(32'h0004_0000));
               if ($urandom_range(3) == 0) op.speed_scale = 16'($urandom_range(16'h01FF));
            end else if (pick < 93) begin
               op.action = ACT_REMOVE;
            end
            send_op(op, 1'b0, no_rsp);
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_rsp_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
